### rtl/core/ak27_pkg.sv
// ---------------------------------------------------------------------------
// ak27_pkg: shared types and constants for the 27-letter autokey decryptor
// Alphabet A-N, N-tilde, O-Z; op codes, status codes, prefix codes, the
// byte-to-symbol decoder and the symbol-to-letter table.
// ---------------------------------------------------------------------------
package ak27_pkg;

   localparam int KEY_DEPTH_DEF = 64;
   localparam int SYM_COUNT     = 27;

   localparam logic [4:0] SYM_ENYE      = 5'd14;
   localparam logic [7:0] BYTE_TILDE    = 8'h7E;
   localparam logic [7:0] BYTE_UTF8_C3  = 8'hC3;
   localparam logic [7:0] BYTE_UTF8_91  = 8'h91;
   localparam logic [7:0] BYTE_N        = 8'h4E;
   localparam logic [7:0] BYTE_HASH     = 8'h23;
   localparam logic [7:0] BYTE_A        = 8'h41;
   localparam logic [7:0] BYTE_O        = 8'h4F;
   localparam logic [7:0] BYTE_Z        = 8'h5A;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_DECRYPT = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_IDLE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PFX_NONE  = 2'd0,
      PFX_TILDE = 2'd1,
      PFX_C3    = 2'd2
   } prefix_type;

   // One accepted transaction handed from the issue stage to the ring stage
   typedef struct packed {
      logic       valid;    // transaction yields a result
      logic       decrypt;  // successful decrypt: key comes from the ring
      status_type status;
      logic       we;       // ring entry gets written
      logic       fwd;      // key must come from the write in flight
   } issue_ctl_type;

   // Ring stage occupancy seen by the issue stage
   typedef struct packed {
      logic valid;
      logic leave;
      logic we;
   } ring_ctl_type;

   localparam logic [7:0] ALPHA_TAB [SYM_COUNT] = '{
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
      8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h23, 8'h4F, 8'h50, 8'h51,
      8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
   };

   // Map a single byte to {known, symbol}
   function automatic logic [5:0] sym_of_byte(input logic [7:0] b);
      logic [5:0] r;
      r = 6'd0;
      if (b >= BYTE_A && b <= BYTE_N) begin
         r = {1'b1, 5'(b - BYTE_A)};
      end else if (b == BYTE_HASH) begin
         r = {1'b1, SYM_ENYE};
      end else if (b >= BYTE_O && b <= BYTE_Z) begin
         r = {1'b1, 5'(b - BYTE_O + 8'd15)};
      end
      return r;
   endfunction

   function automatic logic [7:0] letter_of_sym(input logic [4:0] s);
      logic [7:0] r;
      r = 8'h00;
      if (s < 5'(SYM_COUNT)) begin
         r = ALPHA_TAB[s];
      end
      return r;
   endfunction

endpackage

### rtl/core/ak27_req_bus.sv
// ---------------------------------------------------------------------------
// ak27_req_bus: request channel
// Valid/ready channel carrying an op code and one data byte.
// ---------------------------------------------------------------------------
interface ak27_req_bus;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

### rtl/core/ak27_rsp_bus.sv
// ---------------------------------------------------------------------------
// ak27_rsp_bus: response channel
// Valid/ready channel carrying one plaintext byte with index and status.
// ---------------------------------------------------------------------------
interface ak27_rsp_bus;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [4:0] plain_index;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output out_byte, output plain_index,
                   output status, output last, input ready);
   modport sink   (input valid, input out_byte, input plain_index,
                   input status, input last, output ready);
endinterface

### rtl/core/autokey_decrypt_27_letter.sv
// ---------------------------------------------------------------------------
// autokey_decrypt_27_letter: autokey decryptor over a 27-letter alphabet
// Loads primer key symbols into a key ring, decrypts ciphertext bytes with
// the oldest key symbol and appends each plaintext symbol to the ring.
//
//   channel  | dir | payload                                  | handshake
//   req_bus  | in  | op[1:0], data_byte[7:0]                  | valid/ready
//   rsp_bus  | out | out_byte[7:0], plain_index[4:0],         | valid/ready
//            |     | status[1:0], last                        |
//
// One transaction per cycle unless the response side stalls; a decrypted
// N-tilde occupies the response port as two bytes (C3 then 91). A request
// passes the registered key ring read, then the response register. A ring
// read of the slot being written the same cycle takes the key from the
// write in flight. Synchronous reset clears head, count, pending prefix
// and the pipeline valids; the ring itself is not cleared. A stalled
// response holds the ring stage, which then holds the request side.
// ---------------------------------------------------------------------------
module autokey_decrypt_27_letter #(
   parameter int KEY_DEPTH = ak27_pkg::KEY_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   ak27_req_bus.sink  req_bus,
   ak27_rsp_bus.source rsp_bus
);
   import ak27_pkg::*;

   localparam int PTR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   logic             req_ready;
   ring_ctl_type     ring_ctl;
   issue_ctl_type    issue_ctl;
   logic [4:0]       issue_sym;
   logic [PTR_W-1:0] issue_waddr;
   logic [PTR_W-1:0] rd_addr;
   logic [4:0]       rd_data;
   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [4:0]       ram_wdata;

   assign req_bus.ready = req_ready;

   ak27_issue #(
      .KEY_DEPTH (KEY_DEPTH),
      .PTR_W     (PTR_W)
   ) u_issue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_op        (req_bus.op),
      .req_data_byte (req_bus.data_byte),
      .req_ready     (req_ready),
      .ring_ctl      (ring_ctl),
      .ring_waddr    (ram_waddr),
      .issue_ctl     (issue_ctl),
      .issue_sym     (issue_sym),
      .issue_waddr   (issue_waddr),
      .rd_addr       (rd_addr)
   );

   ak27_key_ram #(
      .KEY_DEPTH (KEY_DEPTH),
      .PTR_W     (PTR_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue_ctl.decrypt),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ak27_emit #(
      .PTR_W (PTR_W)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .issue_ctl       (issue_ctl),
      .issue_sym       (issue_sym),
      .issue_waddr     (issue_waddr),
      .rd_data         (rd_data),
      .ring_ctl        (ring_ctl),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_out_byte    (rsp_bus.out_byte),
      .rsp_plain_index (rsp_bus.plain_index),
      .rsp_status      (rsp_bus.status),
      .rsp_last        (rsp_bus.last)
   );

`ifndef NO_ASSERTIONS
   // A transaction enters the ring stage only when the request is accepted
   a_issue_on_accept: assert property (@(posedge clock) disable iff (reset)
      issue_ctl.valid |-> (req_bus.valid && req_ready))
      else $error("ring stage loaded without an accepted request");

   // A read of the slot written this cycle must be marked for forwarding
   a_fwd_on_collision: assert property (@(posedge clock) disable iff (reset)
      (issue_ctl.decrypt && ram_we && (ram_waddr == rd_addr)) |-> issue_ctl.fwd)
      else $error("read-during-write on key ring without forwarding");

   // Write-back only happens while the ring stage drains
   a_write_on_leave: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ring_ctl.valid && ring_ctl.leave))
      else $error("key ring written outside a ring stage drain");

   // Error responses carry no plaintext
   a_error_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != ST_OK)) |->
         ((rsp_bus.out_byte == 8'h00) && (rsp_bus.plain_index == 5'd0)
          && rsp_bus.last))
      else $error("error response with plaintext payload");
`endif

endmodule

### rtl/core/ak27_key_ram.sv
// ---------------------------------------------------------------------------
// ak27_key_ram: key ring storage
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module ak27_key_ram #(
   parameter int KEY_DEPTH = 64,
   parameter int PTR_W     = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  logic [4:0]       wr_data,
   input  logic             rd_en,
   input  logic [PTR_W-1:0] rd_addr,
   output logic [4:0]       rd_data
);

   logic [4:0] mem [KEY_DEPTH];
   logic [4:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; holds data while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ak27_issue.sv
// ---------------------------------------------------------------------------
// ak27_issue: input decode and ring pointer control
// Decodes the byte and prefix, keeps head, count and pending prefix, and
// issues the ring read and the write slot for each accepted transaction.
// ---------------------------------------------------------------------------
module ak27_issue #(
   parameter int KEY_DEPTH = 64,
   parameter int PTR_W     = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_op,
   input  logic [7:0]               req_data_byte,
   output logic                     req_ready,
   input  ak27_pkg::ring_ctl_type   ring_ctl,
   input  logic [PTR_W-1:0]         ring_waddr,
   output ak27_pkg::issue_ctl_type  issue_ctl,
   output logic [4:0]               issue_sym,
   output logic [PTR_W-1:0]         issue_waddr,
   output logic [PTR_W-1:0]         rd_addr
);
   import ak27_pkg::*;

   localparam int CNT_W = $clog2(KEY_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   prefix_type       prefix_ff, prefix_in;

   logic             accept;
   op_type           op_s;
   logic [5:0]       dec;
   logic             has_result;
   logic             sym_ok;
   logic [4:0]       sym_v;
   prefix_type       pfx_after;
   logic [SUM_W-1:0] sum;
   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] head_next;
   logic             full;
   logic             empty;

   // Accept whenever the ring stage is free or drains this cycle
   assign req_ready = !ring_ctl.valid || ring_ctl.leave;
   assign accept    = req_valid && req_ready;
   assign op_s      = op_type'(req_op);
   assign rd_addr   = head_ff;

   // Ring slot arithmetic: tail = (head + count) mod depth
   always_comb begin
      sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (sum >= SUM_W'(KEY_DEPTH)) begin
         sum = sum - SUM_W'(KEY_DEPTH);
      end
      tail      = sum[PTR_W-1:0];
      head_next = (head_ff == PTR_W'(KEY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      full      = (count_ff == CNT_W'(KEY_DEPTH));
      empty     = (count_ff == '0);
   end

   // Decode byte against the pending prefix
   always_comb begin
      dec        = sym_of_byte(req_data_byte);
      has_result = 1'b1;
      sym_ok     = 1'b0;
      sym_v      = SYM_ENYE;
      pfx_after  = PFX_NONE;
      unique case (prefix_ff)
         PFX_TILDE: begin
            sym_ok = (req_data_byte == BYTE_N);
         end
         PFX_C3: begin
            sym_ok = (req_data_byte == BYTE_UTF8_91);
         end
         default: begin
            if (req_data_byte == BYTE_TILDE) begin
               has_result = 1'b0;
               pfx_after  = PFX_TILDE;
            end else if (req_data_byte == BYTE_UTF8_C3) begin
               has_result = 1'b0;
               pfx_after  = PFX_C3;
            end else begin
               sym_ok = dec[5];
               sym_v  = dec[4:0];
            end
         end
      endcase
   end

   // Next pointer state and the transaction handed to the ring stage
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      prefix_in   = prefix_ff;
      issue_ctl   = '0;
      issue_sym   = sym_v;
      issue_waddr = tail;
      if (accept) begin
         unique case (op_s) inside
            OP_CLEAR: begin
               head_in   = '0;
               count_in  = '0;
               prefix_in = PFX_NONE;
            end
            OP_LOAD, OP_DECRYPT: begin
               prefix_in       = pfx_after;
               issue_ctl.valid = has_result;
               if (has_result) begin
                  if (!sym_ok) begin
                     issue_ctl.status = ST_INVALID;
                  end else if (op_s == OP_LOAD) begin
                     if (full) begin
                        issue_ctl.status = ST_FULL;
                     end else begin
                        issue_ctl.status = ST_OK;
                        issue_ctl.we     = 1'b1;
                        count_in         = count_ff + 1'b1;
                     end
                  end else if (empty) begin
                     issue_ctl.status = ST_EMPTY;
                  end else begin
                     issue_ctl.status  = ST_OK;
                     issue_ctl.we      = 1'b1;
                     issue_ctl.decrypt = 1'b1;
                     issue_ctl.fwd     = ring_ctl.valid && ring_ctl.we &&
                                         (ring_waddr == head_ff);
                     head_in           = head_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Hold pointer state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         prefix_ff <= PFX_NONE;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

### rtl/core/ak27_emit.sv
// ---------------------------------------------------------------------------
// ak27_emit: ring stage and response register
// Takes the key from the ring read (or the forwarded write), computes the
// plaintext symbol, writes it or a loaded key symbol back at the tail and
// sequences the response bytes, two of them for N-tilde.
// ---------------------------------------------------------------------------
module ak27_emit #(
   parameter int PTR_W = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ak27_pkg::issue_ctl_type  issue_ctl,
   input  logic [4:0]               issue_sym,
   input  logic [PTR_W-1:0]         issue_waddr,
   input  logic [4:0]               rd_data,
   output ak27_pkg::ring_ctl_type   ring_ctl,
   output logic                     ram_we,
   output logic [PTR_W-1:0]         ram_waddr,
   output logic [4:0]               ram_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic [4:0]               rsp_plain_index,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);
   import ak27_pkg::*;

   // Ring stage registers
   logic             s1_valid_ff;
   logic             s1_decrypt_ff;
   logic             s1_we_ff;
   logic             s1_fwd_ff;
   status_type       s1_status_ff;
   logic [4:0]       s1_sym_ff;
   logic [4:0]       s1_fwd_data_ff;
   logic [PTR_W-1:0] s1_waddr_ff;

   // Response registers
   logic             o_valid_ff;
   logic             o_dec_ff;
   logic             o_beat_ff;
   status_type       o_status_ff;
   logic [4:0]       o_idx_ff;

   logic       [4:0] key;
   logic       [5:0] diff;
   logic       [4:0] plain;
   logic             o_two;
   logic             o_last;
   logic             rsp_fire;
   logic             o_done;
   logic             s1_leave;

   // Plaintext symbol: (cipher - key) mod 27
   always_comb begin
      key  = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
      diff = {1'b0, s1_sym_ff} + 6'(SYM_COUNT) - {1'b0, key};
      if (s1_sym_ff >= key) begin
         plain = s1_sym_ff - key;
      end else begin
         plain = diff[4:0];
      end
   end

   // Response sequencing
   assign o_two    = o_dec_ff && (o_idx_ff == SYM_ENYE);
   assign o_last   = !(o_two && !o_beat_ff);
   assign rsp_fire = o_valid_ff && rsp_ready;
   assign o_done   = rsp_fire && o_last;
   assign s1_leave = s1_valid_ff && (!o_valid_ff || o_done);

   // Write back on leaving the ring stage
   assign ram_we    = s1_leave && s1_we_ff;
   assign ram_waddr = s1_waddr_ff;
   assign ram_wdata = s1_decrypt_ff ? plain : s1_sym_ff;

   assign ring_ctl.valid = s1_valid_ff;
   assign ring_ctl.leave = s1_leave;
   assign ring_ctl.we    = s1_we_ff;

   // Advance the ring stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (issue_ctl.valid) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_leave) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Capture transaction payload, and the in-flight write when forwarding
   always_ff @(posedge clock) begin
      if (issue_ctl.valid) begin
         s1_decrypt_ff  <= issue_ctl.decrypt;
         s1_we_ff       <= issue_ctl.we;
         s1_fwd_ff      <= issue_ctl.fwd;
         s1_status_ff   <= issue_ctl.status;
         s1_sym_ff      <= issue_sym;
         s1_waddr_ff    <= issue_waddr;
         s1_fwd_data_ff <= ram_wdata;
      end
   end

   // Load, step and drop the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         o_beat_ff  <= 1'b0;
      end else if (s1_leave) begin
         o_valid_ff <= 1'b1;
         o_beat_ff  <= 1'b0;
      end else if (o_done) begin
         o_valid_ff <= 1'b0;
      end else if (rsp_fire) begin
         o_beat_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         o_dec_ff    <= s1_decrypt_ff;
         o_status_ff <= s1_status_ff;
         o_idx_ff    <= s1_decrypt_ff ? plain : 5'd0;
      end
   end

   // Drive response payload
   always_comb begin
      if (!o_dec_ff) begin
         rsp_out_byte = 8'h00;
      end else if (o_two) begin
         rsp_out_byte = o_beat_ff ? BYTE_UTF8_91 : BYTE_UTF8_C3;
      end else begin
         rsp_out_byte = letter_of_sym(o_idx_ff);
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_plain_index = o_idx_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_last        = o_last;

endmodule
